### rtl/txcw_pkg.sv
// Shared types and constants for the text console writer.
// Depends on nothing; txcw_ctrl and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package txcw_pkg;

   // Item function codes
   localparam logic [1:0] FUNC_PUT   = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [7:0] BLANK_CHAR   = 8'h20;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] COLOR_RESET  = 8'h07;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ_WAIT,
      ST_SWEEP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } item_type;

   typedef struct packed {
      logic [15:0] cell_data;
      logic [4:0]  row_pos;
      logic [6:0]  col_pos;
   } result_type;

endpackage

### rtl/txcw_cell_ram.sv
// Screen cell store: single write port, single read port, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module txcw_cell_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] cells_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cells_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/txcw_ctrl.sv
// Sequencer of the console writer: cursor, row base pointer, sweeps over the cell store.
// Depends on txcw_pkg; drives the ports of txcw_cell_ram.
`timescale 1ns / 1ps

module txcw_ctrl #(
   parameter int ROW_COUNT = 25,
   parameter int COL_COUNT = 80
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          item_valid,
   output logic                                          item_ready,
   input  txcw_pkg::item_type                            item,
   input  logic [7:0]                                    cell_color,
   output logic                                          wr_en,
   output logic [$clog2(ROW_COUNT)+$clog2(COL_COUNT)-1:0] wr_addr,
   output logic [15:0]                                   wr_data,
   output logic                                          rd_en,
   output logic [$clog2(ROW_COUNT)+$clog2(COL_COUNT)-1:0] rd_addr,
   input  logic [15:0]                                   rd_data,
   output logic                                          res_valid,
   input  logic                                          res_ready,
   output txcw_pkg::result_type                          res
);

   localparam int RW = $clog2(ROW_COUNT);
   localparam int CW = $clog2(COL_COUNT);
   localparam logic [RW-1:0] ROW_LAST = RW'(ROW_COUNT - 1);
   localparam logic [CW-1:0] COL_LAST = CW'(COL_COUNT - 1);

   txcw_pkg::state_type state_ff, state_in;
   logic [1:0]    func_ff, func_in;
   logic [7:0]    char_ff, char_in;
   logic [4:0]    rrow_ff, rrow_in;
   logic [6:0]    rcol_ff, rcol_in;
   logic [RW-1:0] crow_ff, crow_in;
   logic [CW-1:0] ccol_ff, ccol_in;
   logic [RW-1:0] base_ff, base_in;
   logic [RW-1:0] swp_row_ff, swp_row_in;
   logic [CW-1:0] swp_col_ff, swp_col_in;
   logic          swp_all_ff, swp_all_in;
   logic [15:0]   cell_ff, cell_in;

   logic          is_newline;
   logic          row_done;
   logic          scroll_hit;
   logic          read_ok;
   logic          sweep_end;
   logic [RW-1:0] base_next;
   logic [RW+4:0] rrow_wide;
   logic [CW+6:0] rcol_wide;
   logic [RW+4:0] crow_wide;
   logic [CW+6:0] ccol_wide;

   // Map a logical row onto its physical row through the row base pointer.
   function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
                                              input logic [RW-1:0] base);
      logic [RW:0] sum;
      sum = {1'b0, lrow} + {1'b0, base};
      if (sum >= (RW+1)'(ROW_COUNT)) begin
         sum = sum - (RW+1)'(ROW_COUNT);
      end
      return sum[RW-1:0];
   endfunction

   assign is_newline = (char_ff == txcw_pkg::NEWLINE_CHAR);
   assign row_done   = is_newline || (ccol_ff == COL_LAST);
   assign scroll_hit = row_done && (crow_ff == ROW_LAST);
   assign read_ok    = ({2'b00, rrow_ff} < 7'(ROW_COUNT)) && ({1'b0, rcol_ff} < 8'(COL_COUNT));
   assign sweep_end  = (swp_col_ff == COL_LAST) && (!swp_all_ff || swp_row_ff == ROW_LAST);
   assign base_next  = (base_ff == ROW_LAST) ? '0 : base_ff + 1'b1;
   assign rrow_wide  = {RW'(0), rrow_ff};
   assign rcol_wide  = {CW'(0), rcol_ff};
   assign crow_wide  = {5'd0, crow_ff};
   assign ccol_wide  = {7'd0, ccol_ff};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         txcw_pkg::ST_IDLE: begin
            if (item_valid) state_in = txcw_pkg::ST_EXEC;
         end
         txcw_pkg::ST_EXEC: begin
            unique case (func_ff)
               txcw_pkg::FUNC_PUT:
                  state_in = scroll_hit ? txcw_pkg::ST_SWEEP : txcw_pkg::ST_RESP;
               txcw_pkg::FUNC_CLEAR: state_in = txcw_pkg::ST_SWEEP;
               txcw_pkg::FUNC_READ:
                  state_in = read_ok ? txcw_pkg::ST_READ_WAIT : txcw_pkg::ST_RESP;
               default: state_in = txcw_pkg::ST_RESP;
            endcase
         end
         txcw_pkg::ST_READ_WAIT: state_in = txcw_pkg::ST_RESP;
         txcw_pkg::ST_SWEEP: begin
            if (sweep_end) state_in = txcw_pkg::ST_RESP;
         end
         txcw_pkg::ST_RESP: begin
            if (res_ready) state_in = txcw_pkg::ST_IDLE;
         end
         default: state_in = txcw_pkg::ST_IDLE;
      endcase
   end

   // Datapath and store accesses
   always_comb begin
      func_in    = func_ff;
      char_in    = char_ff;
      rrow_in    = rrow_ff;
      rcol_in    = rcol_ff;
      crow_in    = crow_ff;
      ccol_in    = ccol_ff;
      base_in    = base_ff;
      swp_row_in = swp_row_ff;
      swp_col_in = swp_col_ff;
      swp_all_in = swp_all_ff;
      cell_in    = cell_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = '0;
      item_ready = (state_ff == txcw_pkg::ST_IDLE);
      res_valid  = (state_ff == txcw_pkg::ST_RESP);

      unique case (state_ff)
         txcw_pkg::ST_IDLE: begin
            if (item_valid) begin
               func_in = item.func;
               char_in = item.char_code;
               rrow_in = item.read_row;
               rcol_in = item.read_col;
            end
         end
         txcw_pkg::ST_EXEC: begin
            cell_in = '0;
            unique case (func_ff)
               txcw_pkg::FUNC_PUT: begin
                  if (!is_newline) begin
                     wr_en   = 1'b1;
                     wr_addr = {phys_row(crow_ff, base_ff), ccol_ff};
                     wr_data = {cell_color, char_ff};
                  end
                  if (row_done) begin
                     ccol_in = '0;
                     if (crow_ff == ROW_LAST) begin
                        // old top row becomes the new bottom row; blank it
                        base_in    = base_next;
                        swp_row_in = base_ff;
                        swp_col_in = '0;
                        swp_all_in = 1'b0;
                     end else begin
                        crow_in = crow_ff + 1'b1;
                     end
                  end else begin
                     ccol_in = ccol_ff + 1'b1;
                  end
               end
               txcw_pkg::FUNC_CLEAR: begin
                  crow_in    = '0;
                  ccol_in    = '0;
                  base_in    = '0;
                  swp_row_in = '0;
                  swp_col_in = '0;
                  swp_all_in = 1'b1;
               end
               txcw_pkg::FUNC_READ: begin
                  if (read_ok) begin
                     rd_en   = 1'b1;
                     rd_addr = {phys_row(rrow_wide[RW-1:0], base_ff), rcol_wide[CW-1:0]};
                  end
               end
               default: ;
            endcase
         end
         txcw_pkg::ST_READ_WAIT: cell_in = rd_data;
         txcw_pkg::ST_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = {swp_row_ff, swp_col_ff};
            wr_data = {cell_color, txcw_pkg::BLANK_CHAR};
            if (swp_col_ff == COL_LAST) begin
               swp_col_in = '0;
               swp_row_in = swp_row_ff + 1'b1;
            end else begin
               swp_col_in = swp_col_ff + 1'b1;
            end
         end
         txcw_pkg::ST_RESP: ;
         default: ;
      endcase
   end

   assign res.cell_data = cell_ff;
   assign res.row_pos   = crow_wide[4:0];
   assign res.col_pos   = ccol_wide[6:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= txcw_pkg::ST_IDLE;
         crow_ff  <= '0;
         ccol_ff  <= '0;
         base_ff  <= '0;
      end else begin
         state_ff <= state_in;
         crow_ff  <= crow_in;
         ccol_ff  <= ccol_in;
         base_ff  <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      char_ff    <= char_in;
      rrow_ff    <= rrow_in;
      rcol_ff    <= rcol_in;
      swp_row_ff <= swp_row_in;
      swp_col_ff <= swp_col_in;
      swp_all_ff <= swp_all_in;
      cell_ff    <= cell_in;
   end

endmodule

### rtl/text_console_writer_unit.sv
// Top level of the teletype console writer: color register, response register,
// sequencer and cell store. Depends on txcw_pkg, txcw_ctrl and txcw_cell_ram.
`timescale 1ns / 1ps

//  channel | direction | handshake         | word
//  --------+-----------+-------------------+-----------------------------------------
//  req_    | in        | req_valid/ready   | func, char_code, read_row, read_col
//  rsp_    | out       | rsp_valid/ready   | cell_data, cursor_row_out, cursor_col_out
//  csr_    | in        | csr_valid/ready   | cell_color (attribute byte)
//
//  A put or newline past the bottom row also blanks the new last row; clear blanks
//  every cell. Scrolling only rotates a row base pointer.
//  Reset: cursor home, row base 0, color 7; cells hold garbage until the first clear.
//  Stalls: a new word is taken while the last result waits in the response register;
//  the next result holds until that register drains.

module text_console_writer_unit #(
   parameter int ROW_COUNT = 25,
   parameter int COL_COUNT = 80
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_char_code,
   input  logic [4:0]  req_read_row,
   input  logic [6:0]  req_read_col,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_cell_data,
   output logic [4:0]  rsp_cursor_row_out,
   output logic [6:0]  rsp_cursor_col_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_cell_color
);

   localparam int ADDR_W = $clog2(ROW_COUNT) + $clog2(COL_COUNT);

   logic [7:0]            cell_color_ff, cell_color_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   txcw_pkg::result_type  rsp_word_ff, rsp_word_in;
   txcw_pkg::item_type    item;
   txcw_pkg::result_type  res;
   logic                  res_valid;
   logic                  res_ready;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [15:0]           wr_data;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [15:0]           rd_data;

   // Bundle the request word for the sequencer.
   assign item.func      = req_func;
   assign item.char_code = req_char_code;
   assign item.read_row  = req_read_row;
   assign item.read_col  = req_read_col;

   // Color writes are always taken; they must only arrive while the block is idle, which the block does not enforce.
   assign csr_ready     = 1'b1;
   assign cell_color_in = (csr_valid) ? csr_cell_color : cell_color_ff;

   // Hold the result until taken; accept a new one when empty or draining.
   assign res_ready    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = (res_valid && res_ready) ? 1'b1 :
                         (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_word_in  = (res_valid && res_ready) ? res : rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_color_ff <= txcw_pkg::COLOR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cell_color_ff <= cell_color_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_data      = rsp_word_ff.cell_data;
   assign rsp_cursor_row_out = rsp_word_ff.row_pos;
   assign rsp_cursor_col_out = rsp_word_ff.col_pos;

   txcw_ctrl #(
      .ROW_COUNT (ROW_COUNT),
      .COL_COUNT (COL_COUNT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_valid),
      .item_ready (req_ready),
      .item       (item),
      .cell_color (cell_color_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   txcw_cell_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (16)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // One word at a time: after an accept the request side closes.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a word is in flight");

   // A reported cursor never lies outside the screen.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({2'b00, rsp_cursor_row_out} < 7'(ROW_COUNT)
                     && {1'b0, rsp_cursor_col_out} < 8'(COL_COUNT)))
      else $error("cursor outside the screen");

   // The store is never written and read in the same cycle by the sequencer.
   assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("cell store write and read overlap");

endmodule
